@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a cause is followed by an effect in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("assertion failed");

`endif

@@ hdl/alr_pkg.sv @@
// ---------------------------------------------------------------------------
// alr_pkg
// Shared widths, types and the battery scaling for the ambient reject block.
// ---------------------------------------------------------------------------
package alr_pkg;

    localparam int SAMPLE_BITS   = 10;
    localparam int LEVEL_W       = 10;
    localparam int MV_W          = 15;
    localparam int NUM_LANES     = 4;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int MV_FULL_SCALE = 18300;
    localparam int MV_INT        = MV_FULL_SCALE / SAMPLE_MAX;
    localparam int MV_FRAC       = MV_FULL_SCALE % SAMPLE_MAX;

    localparam int IN_FIELDS_W   = SAMPLE_BITS * (NUM_LANES + 1);
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = 3 + MV_W + NUM_LANES * LEVEL_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    typedef struct packed {
        logic store_lit;
        logic store_dark;
        logic tick;
    } t_lane_ctl;

    typedef struct packed {
        logic            led1;
        logic            led2;
        logic            start;
        logic [MV_W-1:0] battery_mv;
    } t_ctl_res;

    // floor(s * MV_FULL_SCALE / SAMPLE_MAX); the divisor is 2^k - 1, so the
    // fractional part folds into one add and one compare.
    function automatic logic [MV_W-1:0] to_millivolts(input logic [SAMPLE_BITS-1:0] s);
        logic [2*SAMPLE_BITS-1:0] t;
        logic [SAMPLE_BITS:0]     sum;
        logic [MV_W-1:0]          q;
        logic [MV_W-1:0]          whole;
        t     = (2*SAMPLE_BITS)'(s) * (2*SAMPLE_BITS)'(MV_FRAC);
        sum   = {1'b0, t[2*SAMPLE_BITS-1:SAMPLE_BITS]} + {1'b0, t[SAMPLE_BITS-1:0]};
        q     = MV_W'(t[2*SAMPLE_BITS-1:SAMPLE_BITS])
              + MV_W'(sum >= (SAMPLE_BITS+1)'(SAMPLE_MAX));
        whole = MV_W'(MV_W'(s) * MV_W'(MV_INT));
        return MV_W'(whole + q);
    endfunction

endpackage

@@ hdl/alr_lane.sv @@
// ---------------------------------------------------------------------------
// alr_lane
// One channel: lit and dark capture, difference (held when dark exceeds lit), two-deep history.
// ---------------------------------------------------------------------------
module alr_lane (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  alr_pkg::t_lane_ctl            i_ctl,
    input  logic [alr_pkg::LEVEL_W-1:0]   i_sample,
    output logic [alr_pkg::LEVEL_W-1:0]   o_avg_next
);
    import alr_pkg::*;

    logic [LEVEL_W-1:0] r_lit, n_lit;
    logic [LEVEL_W-1:0] r_dark, n_dark;
    logic [LEVEL_W-1:0] r_newest, n_newest;
    logic [LEVEL_W-1:0] r_older, n_older;
    logic [LEVEL_W:0]   sum;

    always_comb begin
        n_lit    = i_ctl.store_lit  ? i_sample : r_lit;
        n_dark   = i_ctl.store_dark ? i_sample : r_dark;
        n_newest = r_newest;
        n_older  = r_older;
        if (i_ctl.tick) begin
            n_older = r_newest;
            if (r_lit >= r_dark) begin
                n_newest = r_lit - r_dark;
            end
        end
        sum        = {1'b0, n_newest} + {1'b0, n_older};
        o_avg_next = sum[LEVEL_W:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit    <= '0;
            r_dark   <= '0;
            r_newest <= '0;
            r_older  <= '0;
        end else begin
            r_lit    <= n_lit;
            r_dark   <= n_dark;
            r_newest <= n_newest;
            r_older  <= n_older;
        end
    end

endmodule

@@ hdl/alr_ctrl.sv @@
// ---------------------------------------------------------------------------
// alr_ctrl
// Phase sequencer, LED drive, battery scaling and per-lane strobes.
// ---------------------------------------------------------------------------
module alr_ctrl (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_accept,
    input  logic                                       i_tick,
    input  logic [alr_pkg::SAMPLE_BITS-1:0]            i_battery_sample,
    output alr_pkg::t_lane_ctl [alr_pkg::NUM_LANES-1:0] o_lane_ctl,
    output alr_pkg::t_ctl_res                          o_res_next
);
    import alr_pkg::*;

    t_phase          r_phase, n_phase;
    logic            r_led1, n_led1;
    logic            r_led2, n_led2;
    logic [MV_W-1:0] r_battery, n_battery;
    logic            start;
    logic            lit_lo, dark_lo, lit_hi, dark_hi;

    always_comb begin
        n_phase   = r_phase;
        n_led1    = r_led1;
        n_led2    = r_led2;
        n_battery = r_battery;
        start     = 1'b1;
        lit_lo    = 1'b0;
        dark_lo   = 1'b0;
        lit_hi    = 1'b0;
        dark_hi   = 1'b0;
        if (i_accept && !i_tick) begin
            n_battery = to_millivolts(i_battery_sample);
            unique case (r_phase)
                PH_0: begin
                    n_led1  = 1'b1;
                    n_led2  = 1'b0;
                    n_phase = PH_1;
                end
                PH_1: begin
                    dark_lo = 1'b1;
                    lit_hi  = 1'b1;
                    n_led1  = 1'b0;
                    n_led2  = 1'b1;
                    n_phase = PH_2;
                end
                PH_2: begin
                    lit_lo  = 1'b1;
                    dark_hi = 1'b1;
                    n_led1  = 1'b1;
                    n_led2  = 1'b1;
                    n_phase = PH_0;
                    start   = 1'b0;
                end
                default: begin
                    n_phase = PH_0;
                    start   = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            o_lane_ctl[i].tick = i_accept && i_tick;
            if (i < NUM_LANES / 2) begin
                o_lane_ctl[i].store_lit  = lit_lo;
                o_lane_ctl[i].store_dark = dark_lo;
            end else begin
                o_lane_ctl[i].store_lit  = lit_hi;
                o_lane_ctl[i].store_dark = dark_hi;
            end
        end
        o_res_next.led1       = n_led1;
        o_res_next.led2       = n_led2;
        o_res_next.start      = start;
        o_res_next.battery_mv = n_battery;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_0;
            r_led1    <= 1'b0;
            r_led2    <= 1'b0;
            r_battery <= '0;
        end else begin
            r_phase   <= n_phase;
            r_led1    <= n_led1;
            r_led2    <= n_led2;
            r_battery <= n_battery;
        end
    end

endmodule

@@ hdl/alr_merge.sv @@
// ---------------------------------------------------------------------------
// alr_merge
// Collect lane averages and control fields into the output beat register.
// ---------------------------------------------------------------------------
module alr_merge (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_accept,
    input  alr_pkg::t_ctl_res                                  i_res,
    input  logic [alr_pkg::NUM_LANES-1:0][alr_pkg::LEVEL_W-1:0] i_avg,
    input  logic                                               i_m_tready,
    output logic                                               o_space,
    output logic                                               o_m_tvalid,
    output logic [alr_pkg::OUT_TDATA_W-1:0]                    o_m_tdata
);
    import alr_pkg::*;

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_tdata;

    assign o_space    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_tdata <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, i_avg, i_res.battery_mv,
                        i_res.start, i_res.led2, i_res.led1};
        end
    end

endmodule

@@ hdl/led_pulsed_ambient_reject.sv @@
// ---------------------------------------------------------------------------
// led_pulsed_ambient_reject
// Pulsed-IR four-channel front end with ambient rejection and averaging.
// ---------------------------------------------------------------------------
//  channel  dir  signals                         contents
//  s        in   i_s_tvalid/o_s_tready/tdata     battery, samples a..d
//           in   i_s_tuser                       operation (1 = tick)
//  m        out  o_m_tvalid/i_m_tready/tdata     leds, start, battery_mv, averages
//
//  One beat in per cycle, one result beat out per input beat, in the next cycle.
//  The output register frees up in the same cycle it is taken, so input and
//  output run back to back; input stalls only while a result waits.
//  Synchronous active-low reset clears phase, levels, history and valid.
// ---------------------------------------------------------------------------
module led_pulsed_ambient_reject (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [9:0] battery_sample, [19:10] sample_a, [29:20] sample_b,
    // [39:30] sample_c, [49:40] sample_d, [55:50] zero
    input  logic [alr_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [0] operation
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] led1_level, [1] led2_level, [2] start_conversion, [17:3] battery_mv,
    // [27:18] average_0, [37:28] average_1, [47:38] average_2,
    // [57:48] average_3, [63:58] zero
    output logic [alr_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import alr_pkg::*;

    logic                                    accept;
    logic                                    space;
    t_lane_ctl [NUM_LANES-1:0]               lane_ctl;
    t_ctl_res                                res_next;
    logic [NUM_LANES-1:0][LEVEL_W-1:0]       avg_next;

    assign o_s_tready = space;
    assign accept     = i_s_tvalid && space;

    alr_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_tick           (i_s_tuser),
        .i_battery_sample (i_s_tdata[SAMPLE_BITS-1:0]),
        .o_lane_ctl       (lane_ctl),
        .o_res_next       (res_next)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        alr_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl[g]),
            .i_sample   (LEVEL_W'(i_s_tdata[SAMPLE_BITS*(g+1) +: SAMPLE_BITS])),
            .o_avg_next (avg_next[g])
        );
    end

    alr_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_res      (res_next),
        .i_avg      (avg_next),
        .i_m_tready (i_m_tready),
        .o_space    (space),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

@@ hdl/alr_checker.sv @@
// ---------------------------------------------------------------------------
// alr_checker
// Port-level checks for the ambient reject block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module alr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `ASSERT_CLK(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready)
    `ASSERT_NEXT(a_beat_follows, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid)
    `ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser, o_m_tdata[2])
    `ASSERT_CLK(a_mv_range, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tdata[17:3] <= 15'd18300 && o_m_tdata[63:58] == 6'd0))

endmodule

bind led_pulsed_ambient_reject alr_checker u_alr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of led_pulsed_ambient_reject. Conversion and tick
// beats go in and every result beat is compared field by field against a
// local model of the LED phase counter, battery scaling and the two-deep
// ambient-free history. Traffic runs through phases of sender gaps and
// receiver stalls, plus one long receiver hold-off that backs up the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic       OP_CONVERT   = 1'b0;
    localparam logic       OP_TICK      = 1'b1;
    localparam logic [1:0] PH_LED1      = 2'd0;
    localparam logic [1:0] PH_SPLIT     = 2'd1;
    localparam logic [1:0] PH_BOTH      = 2'd2;
    localparam int         MV_SCALE     = 18300;
    localparam int         SAMPLE_FULL  = 1023;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 10;

    typedef logic [3:0][9:0] t_quad;

    typedef struct packed {
        logic        led1;
        logic        led2;
        logic        start;
        logic [14:0] battery_mv;
        t_quad       average;
    } t_readout;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    // [9:0] battery_sample, [19:10] sample_a, [29:20] sample_b,
    // [39:30] sample_c, [49:40] sample_d, [55:50] zero
    logic [alr_pkg::IN_TDATA_W-1:0] i_s_tdata = '0;
    // [0] operation
    logic                          i_s_tuser  = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    // [0] led1_level, [1] led2_level, [2] start_conversion, [17:3] battery_mv,
    // [27:18] average_0, [37:28] average_1, [47:38] average_2,
    // [57:48] average_3, [63:58] zero
    logic [alr_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    led_pulsed_ambient_reject dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [1:0]  led_phase   = PH_LED1;
    t_quad       lit_held    = '0;
    t_quad       dark_held   = '0;
    t_quad       newest_diff = '0;
    t_quad       older_diff  = '0;
    logic        led1_on     = 1'b0;
    logic        led2_on     = 1'b0;
    logic [14:0] battery_mv_held = '0;

    t_readout pending_readouts[$];
    int       beats_sent     = 0;
    int       fault_count    = 0;
    int       cycle_count    = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    int       hold_requests  = 0;
    int       holds_served   = 0;
    int       hold_left      = 0;

    function automatic t_readout reject_ambient(input logic op, input logic [9:0] battery,
                                                input t_quad s);
        t_readout r;
        int       i;
        if (op == OP_CONVERT) begin
            unique case (led_phase)
                PH_LED1: begin
                    led1_on = 1'b1;
                    led2_on = 1'b0;
                end
                PH_SPLIT: begin
                    dark_held[0] = s[0];
                    dark_held[1] = s[1];
                    lit_held[2]  = s[2];
                    lit_held[3]  = s[3];
                    led1_on      = 1'b0;
                    led2_on      = 1'b1;
                end
                PH_BOTH: begin
                    lit_held[0]  = s[0];
                    lit_held[1]  = s[1];
                    dark_held[2] = s[2];
                    dark_held[3] = s[3];
                    led1_on      = 1'b1;
                    led2_on      = 1'b1;
                end
                default: ;
            endcase
            battery_mv_held = 15'((int'(battery) * MV_SCALE) / SAMPLE_FULL);
            r.start   = (led_phase < PH_BOTH);
            led_phase = (led_phase < PH_BOTH) ? led_phase + 2'd1 : PH_LED1;
        end else begin
            for (i = 0; i < 4; i++) begin
                older_diff[i] = newest_diff[i];
                if (lit_held[i] >= dark_held[i])
                    newest_diff[i] = lit_held[i] - dark_held[i];
            end
            r.start = 1'b1;
        end
        r.led1       = led1_on;
        r.led2       = led2_on;
        r.battery_mv = battery_mv_held;
        for (i = 0; i < 4; i++)
            r.average[i] = 10'((11'(newest_diff[i]) + 11'(older_diff[i])) >> 1);
        return r;
    endfunction

    function automatic t_quad quad(input logic [9:0] a, b, c, d);
        return {d, c, b, a};
    endfunction

    function automatic logic [9:0] rand_level();
        unique case ($urandom_range(7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(1023));
        endcase
    endfunction

    function automatic t_quad rand_quad();
        return quad(rand_level(), rand_level(), rand_level(), rand_level());
    endfunction

    task automatic send_beat(input logic op, input logic [9:0] battery, input t_quad s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {6'b0, s[3], s[2], s[1], s[0], battery};
        do @(posedge i_clk); while (!o_s_tready);
        pending_readouts.push_back(reject_ambient(op, battery, s));
        beats_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // realign to the first phase, run one conversion sequence, then tick
    task automatic send_frame();
        int ticks;
        ticks = $urandom_range(1, 3);
        while (led_phase != PH_LED1)
            send_beat(OP_CONVERT, rand_level(), rand_quad());
        repeat (3) send_beat(OP_CONVERT, rand_level(), rand_quad());
        repeat (ticks) send_beat(OP_TICK, rand_level(), rand_quad());
    endtask

    task automatic test_tick_from_reset();
        send_beat(OP_TICK, 10'd1023, quad(10'd1023, 10'd1023, 10'd1023, 10'd1023));
        send_beat(OP_TICK, 10'd0, quad(10'd0, 10'd0, 10'd0, 10'd0));
        drain();
    endtask

    task automatic test_full_scale();
        send_beat(OP_CONVERT, 10'd0, quad(10'd1023, 10'd1023, 10'd1023, 10'd1023));
        send_beat(OP_CONVERT, 10'd1023, quad(10'd1023, 10'd1023, 10'd1023, 10'd1023));
        send_beat(OP_CONVERT, 10'd1, quad(10'd1023, 10'd1023, 10'd0, 10'd0));
        send_beat(OP_TICK, 10'd0, quad(10'd0, 10'd0, 10'd0, 10'd0));
        send_beat(OP_TICK, 10'd1023, quad(10'd1023, 10'd1023, 10'd1023, 10'd1023));
        drain();
    endtask

    task automatic test_dark_above_lit();
        send_beat(OP_CONVERT, 10'd512, quad(10'd0, 10'd0, 10'd0, 10'd0));
        send_beat(OP_CONVERT, 10'd1022, quad(10'd1000, 10'd1023, 10'd5, 10'd0));
        send_beat(OP_CONVERT, 10'd2, quad(10'd10, 10'd1022, 10'd600, 10'd1));
        send_beat(OP_TICK, 10'd0, quad(10'd0, 10'd0, 10'd0, 10'd0));
        send_beat(OP_TICK, 10'd0, quad(10'd0, 10'd0, 10'd0, 10'd0));
        drain();
    endtask

    task automatic test_equal_levels();
        send_beat(OP_CONVERT, 10'd341, quad(10'd1, 10'd2, 10'd3, 10'd4));
        send_beat(OP_CONVERT, 10'd682, quad(10'd700, 10'd1, 10'd1023, 10'd512));
        send_beat(OP_CONVERT, 10'd1023, quad(10'd700, 10'd1, 10'd1023, 10'd512));
        send_beat(OP_TICK, 10'd0, quad(10'd0, 10'd0, 10'd0, 10'd0));
        send_beat(OP_TICK, 10'd0, quad(10'd0, 10'd0, 10'd0, 10'd0));
        drain();
    endtask

    task automatic test_back_pressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        repeat (12) send_frame();
        drain();
    endtask

    task automatic run_traffic(input int beats, input int idle_pct, input int stall_pct);
        int first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = beats_sent;
        while (beats_sent - first < beats) begin
            if ($urandom_range(9) < 8)
                send_frame();
            else
                repeat ($urandom_range(1, 6))
                    send_beat(1'($urandom_range(1)), rand_level(), rand_quad());
        end
        drain();
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
                $display("mismatch %s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            i_m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_readouts
        t_readout want;
        int       i;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_readouts.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result beat, tdata %h", o_m_tdata);
            end else begin
                want = pending_readouts.pop_front();
                check_field("led1_level", int'(want.led1), int'(o_m_tdata[0]));
                check_field("led2_level", int'(want.led2), int'(o_m_tdata[1]));
                check_field("start_conversion", int'(want.start), int'(o_m_tdata[2]));
                check_field("battery_mv", int'(want.battery_mv), int'(o_m_tdata[17:3]));
                for (i = 0; i < 4; i++)
                    check_field($sformatf("average_%0d", i), int'(want.average[i]),
                                int'(o_m_tdata[18 + 10*i +: 10]));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tick_from_reset();
        test_full_scale();
        test_dark_above_lit();
        test_equal_levels();
        run_traffic(400, 0, 0);
        run_traffic(400, 83, 0);
        test_back_pressure();
        run_traffic(400, 0, 83);
        run_traffic(400, 26, 26);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
